### rtl/core/sdf_pkg.sv
package sdf_pkg;

    localparam int MAX_POINTS_DEF = 64;
    localparam int MAX_DIMS_DEF   = 8;

    localparam int COORD_W   = 32;
    localparam int NUM_W     = 7;
    localparam int MASK_W    = 8;
    localparam int DIMS_W    = 4;
    localparam int CFG_W     = 8;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_DIM_MASK    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIMS_IN_USE = 1'b1;

    localparam logic [MASK_W-1:0] MASK_RESET = 8'hFF;
    localparam logic [DIMS_W-1:0] DIMS_RESET = 4'd8;

    typedef struct packed {
        logic signed [COORD_W-1:0] coordinate;
        logic                      last_coordinate;
    } request_t;

    typedef struct packed {
        logic [NUM_W-1:0] point_number;
        logic [NUM_W-1:0] skyline_count;
        logic             last_of_run;
        logic             overflow;
    } result_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_CMP,
        S_FLUSH
    } state_t;

endpackage

### rtl/core/sdf_store.sv
module sdf_store #(
    parameter int DEPTH = sdf_pkg::MAX_POINTS_DEF * sdf_pkg::MAX_DIMS_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                        clk,
    input  logic                        we,
    input  logic [AW-1:0]               waddr,
    input  logic [sdf_pkg::COORD_W-1:0] wdata,
    input  logic [AW-1:0]               raddr_a,
    input  logic [AW-1:0]               raddr_b,
    output logic [sdf_pkg::COORD_W-1:0] rdata_a,
    output logic [sdf_pkg::COORD_W-1:0] rdata_b
);

    logic [sdf_pkg::COORD_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

### rtl/core/skyline_dominance_filter.sv
// Loading: one coordinate per cycle, busy stays low, no result.
// The request with last_coordinate starts the query if at least one point is stored. Each ordered
// pair (j, i) is settled in S_READ alone when j equals i; else its dimensions in use are walked in
// order, a masked-off one in S_READ alone and a compared one by a store read in S_READ, then a
// compare in S_CMP, ending at the first loss. Results are one-cycle strobes and cannot stall.
// Reset clears control and sets the configuration to its defaults; the coordinate store is not cleared.
module skyline_dominance_filter #(
    parameter int MAX_POINTS = sdf_pkg::MAX_POINTS_DEF,
    parameter int MAX_DIMS   = sdf_pkg::MAX_DIMS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  sdf_pkg::request_t             request,
    output logic                          result_valid,
    output sdf_pkg::result_t              result,
    input  logic                          cfg_we,
    input  logic [sdf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [sdf_pkg::CFG_W-1:0]     cfg_data
);

    localparam int DEPTH = MAX_POINTS * MAX_DIMS;
    localparam int AW    = $clog2(DEPTH);
    localparam int PW    = $clog2(MAX_POINTS);
    localparam int CW    = $clog2(MAX_POINTS + 1);
    localparam int DW    = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int NDW   = $clog2(MAX_DIMS + 1);
    localparam int MW    = (MAX_DIMS > sdf_pkg::MASK_W) ? MAX_DIMS : sdf_pkg::MASK_W;
    localparam int NW    = sdf_pkg::NUM_W;

    sdf_pkg::state_t state_reg, state_next;

    logic [sdf_pkg::MASK_W-1:0] dim_mask_reg;
    logic [sdf_pkg::DIMS_W-1:0] dims_reg;

    logic [CW-1:0] pc_reg, pc_next;
    logic [DW-1:0] dc_reg, dc_next;
    logic          ovf_reg, ovf_next;
    logic [PW-1:0] i_reg, i_next;
    logic [PW-1:0] j_reg, j_next;
    logic [DW-1:0] d_reg, d_next;
    logic          strict_reg, strict_next;
    logic [NW-1:0] emitted_reg, emitted_next;
    logic          pend_valid_reg, pend_valid_next;
    logic [NW-1:0] pend_num_reg, pend_num_next;
    logic [NW-1:0] pend_cnt_reg, pend_cnt_next;
    logic          result_valid_reg, result_valid_next;
    sdf_pkg::result_t result_reg, result_next;

    logic [4:0]     dims_ext;
    logic [4:0]     eff_dims;
    logic [NDW-1:0] nd_eff;
    logic [MW-1:0]  mask_ext;

    logic                        accept;
    logic                        pc_full;
    logic [NDW-1:0]              dc_inc;
    logic [CW-1:0]               pc_load;
    logic [DW-1:0]               dc_load;
    logic                        ovf_load;
    logic                        wr_en;
    logic [AW-1:0]               wr_addr;
    logic [AW-1:0]               rd_addr_a;
    logic [AW-1:0]               rd_addr_b;
    logic [sdf_pkg::COORD_W-1:0] rd_a;
    logic [sdf_pkg::COORD_W-1:0] rd_b;

    logic dim_last;
    logic pair_done;
    logic pair_dom;
    logic strict_cur;
    logic j_last;
    logic i_last;

    // Effective dimension count: zero acts as one, large values clip to MAX_DIMS.
    always_comb
    begin
        dims_ext = {1'b0, dims_reg};
        if (dims_ext == 5'd0)
        begin
            eff_dims = 5'd1;
        end
        else if (dims_ext > 5'(MAX_DIMS))
        begin
            eff_dims = 5'(MAX_DIMS);
        end
        else
        begin
            eff_dims = dims_ext;
        end
        nd_eff   = NDW'(eff_dims);
        mask_ext = MW'(dim_mask_reg);
    end

    assign accept  = start && (state_reg == sdf_pkg::S_IDLE);
    assign pc_full = (pc_reg == CW'(MAX_POINTS));
    assign dc_inc  = NDW'(dc_reg) + NDW'(1);
    assign wr_en   = accept && !pc_full;
    assign wr_addr = AW'(pc_reg[PW-1:0]) * AW'(MAX_DIMS) + AW'(dc_reg);

    assign rd_addr_a = AW'(j_reg) * AW'(MAX_DIMS) + AW'(d_reg);
    assign rd_addr_b = AW'(i_reg) * AW'(MAX_DIMS) + AW'(d_reg);

    assign dim_last = ((NDW'(d_reg) + NDW'(1)) == nd_eff);
    assign j_last   = ((CW'(j_reg) + CW'(1)) == pc_reg);
    assign i_last   = ((CW'(i_reg) + CW'(1)) == pc_reg);

    sdf_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .clk     (clk),
        .we      (wr_en),
        .waddr   (wr_addr),
        .wdata   (request.coordinate),
        .raddr_a (rd_addr_a),
        .raddr_b (rd_addr_b),
        .rdata_a (rd_a),
        .rdata_b (rd_b)
    );

    always_comb
    begin
        pc_load  = pc_reg;
        dc_load  = dc_reg;
        ovf_load = ovf_reg;
        if (!pc_full)
        begin
            if (dc_inc >= nd_eff)
            begin
                dc_load = '0;
                pc_load = pc_reg + CW'(1);
            end
            else
            begin
                dc_load = DW'(dc_inc);
            end
        end
        else
        begin
            ovf_load = 1'b1;
        end
    end

    always_comb
    begin
        state_next        = state_reg;
        pc_next           = pc_reg;
        dc_next           = dc_reg;
        ovf_next          = ovf_reg;
        i_next            = i_reg;
        j_next            = j_reg;
        d_next            = d_reg;
        strict_next       = strict_reg;
        emitted_next      = emitted_reg;
        pend_valid_next   = pend_valid_reg;
        pend_num_next     = pend_num_reg;
        pend_cnt_next     = pend_cnt_reg;
        result_valid_next = 1'b0;
        result_next       = result_reg;
        pair_done         = 1'b0;
        pair_dom          = 1'b0;
        strict_cur        = strict_reg;

        unique case (state_reg)
            sdf_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    if (request.last_coordinate)
                    begin
                        dc_next = '0;
                        if (pc_load == '0)
                        begin
                            pc_next  = '0;
                            ovf_next = 1'b0;
                        end
                        else
                        begin
                            pc_next         = pc_load;
                            ovf_next        = ovf_load;
                            i_next          = '0;
                            j_next          = '0;
                            d_next          = '0;
                            strict_next     = 1'b0;
                            emitted_next    = '0;
                            pend_valid_next = 1'b0;
                            state_next      = sdf_pkg::S_READ;
                        end
                    end
                    else
                    begin
                        pc_next  = pc_load;
                        dc_next  = dc_load;
                        ovf_next = ovf_load;
                    end
                end
            end

            sdf_pkg::S_READ:
            begin
                if (j_reg == i_reg)
                begin
                    pair_done = 1'b1;
                end
                else if (!mask_ext[d_reg])
                begin
                    if (dim_last)
                    begin
                        pair_done = 1'b1;
                        pair_dom  = strict_reg;
                    end
                    else
                    begin
                        d_next = d_reg + DW'(1);
                    end
                end
                else
                begin
                    state_next = sdf_pkg::S_CMP;
                end
            end

            sdf_pkg::S_CMP:
            begin
                state_next = sdf_pkg::S_READ;
                if ($signed(rd_a) > $signed(rd_b))
                begin
                    pair_done = 1'b1;
                end
                else
                begin
                    strict_cur = strict_reg || ($signed(rd_a) < $signed(rd_b));
                    if (dim_last)
                    begin
                        pair_done = 1'b1;
                        pair_dom  = strict_cur;
                    end
                    else
                    begin
                        d_next      = d_reg + DW'(1);
                        strict_next = strict_cur;
                    end
                end
            end

            sdf_pkg::S_FLUSH:
            begin
                if (pend_valid_reg)
                begin
                    result_valid_next         = 1'b1;
                    result_next.point_number  = pend_num_reg;
                    result_next.skyline_count = pend_cnt_reg;
                    result_next.last_of_run   = 1'b1;
                    result_next.overflow      = ovf_reg;
                end
                pend_valid_next = 1'b0;
                emitted_next    = '0;
                pc_next         = '0;
                dc_next         = '0;
                ovf_next        = 1'b0;
                state_next      = sdf_pkg::S_IDLE;
            end

            default:
            begin
                state_next = sdf_pkg::S_IDLE;
            end
        endcase

        // A finished pair beats point i, moves to the next rival, or, after the last, keeps point i.
        if (pair_done)
        begin
            d_next      = '0;
            strict_next = 1'b0;
            if (pair_dom || j_last)
            begin
                j_next = '0;
                if (!pair_dom)
                begin
                    // Point i survived: release the held result, hold this one.
                    if (pend_valid_reg)
                    begin
                        result_valid_next         = 1'b1;
                        result_next.point_number  = pend_num_reg;
                        result_next.skyline_count = pend_cnt_reg;
                        result_next.last_of_run   = 1'b0;
                        result_next.overflow      = ovf_reg;
                    end
                    pend_valid_next = 1'b1;
                    pend_num_next   = NW'(i_reg) + NW'(1);
                    pend_cnt_next   = emitted_reg + NW'(1);
                    emitted_next    = emitted_reg + NW'(1);
                end
                if (i_last)
                begin
                    state_next = sdf_pkg::S_FLUSH;
                end
                else
                begin
                    i_next     = i_reg + PW'(1);
                    state_next = sdf_pkg::S_READ;
                end
            end
            else
            begin
                j_next     = j_reg + PW'(1);
                state_next = sdf_pkg::S_READ;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sdf_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dim_mask_reg     <= sdf_pkg::MASK_RESET;
            dims_reg         <= sdf_pkg::DIMS_RESET;
            pc_reg           <= '0;
            dc_reg           <= '0;
            ovf_reg          <= 1'b0;
            i_reg            <= '0;
            j_reg            <= '0;
            d_reg            <= '0;
            strict_reg       <= 1'b0;
            emitted_reg      <= '0;
            pend_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    sdf_pkg::CFG_DIM_MASK:    dim_mask_reg <= cfg_data[sdf_pkg::MASK_W-1:0];
                    sdf_pkg::CFG_DIMS_IN_USE: dims_reg     <= cfg_data[sdf_pkg::DIMS_W-1:0];
                    default:                  dims_reg     <= dims_reg;
                endcase
            end
            pc_reg           <= pc_next;
            dc_reg           <= dc_next;
            ovf_reg          <= ovf_next;
            i_reg            <= i_next;
            j_reg            <= j_next;
            d_reg            <= d_next;
            strict_reg       <= strict_next;
            emitted_reg      <= emitted_next;
            pend_valid_reg   <= pend_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_num_reg <= pend_num_next;
        pend_cnt_reg <= pend_cnt_next;
        result_reg   <= result_next;
    end

    assign busy         = (state_reg != sdf_pkg::S_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

### rtl/core/sdf_checker.sv
module sdf_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input sdf_pkg::request_t request,
    input logic              result_valid,
    input sdf_pkg::result_t  result
);

    // A count of zero would mean a result was sent before any point survived.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.skyline_count != '0) && (result.point_number != '0))
    else $error("skyline result with zero count or zero point number");

    // A loading request never produces a result in the following cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && !request.last_coordinate) |=> !result_valid)
    else $error("result following a loading request");

    // The final result of a query is not followed directly by another.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.last_of_run) |=> !result_valid)
    else $error("result directly after the final one of a query");

    // Results other than the final one arrive while the query is still running.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.last_of_run) |-> busy)
    else $error("non-final result while idle");

endmodule

bind skyline_dominance_filter sdf_checker u_sdf_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .request      (request),
    .result_valid (result_valid),
    .result       (result)
);
